>>> rtl/rbm_pkg.sv
// Shared types, constants and Booth recoding function for the radix-4 Booth multiplier.
// Depends on nothing; every other file of the block imports it.
package rbm_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int PROD_W            = 64;
    localparam int WCODE_W           = 2;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TWOS_COMP  = 1'b1;

    // Mode and width travel with each item so the status matches its operands
    typedef struct packed {
        logic               twos_comp;
        logic [WCODE_W-1:0] width_code;
    } rbm_meta_t;

    typedef enum logic [2:0] {
        BOOTH_ZERO,
        BOOTH_POS1,
        BOOTH_POS2,
        BOOTH_NEG2,
        BOOTH_NEG1
    } booth_t;

    // Triple is {b[2g+1], b[2g], b[2g-1]}
    function automatic booth_t booth_decode(input logic [2:0] triple);
        booth_t d;
        case (triple)
            3'b001, 3'b010: d = BOOTH_POS1;
            3'b011:         d = BOOTH_POS2;
            3'b100:         d = BOOTH_NEG2;
            3'b101, 3'b110: d = BOOTH_NEG1;
            default:        d = BOOTH_ZERO;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/rbm_in_if.sv
// Operand channel: valid/ready handshake carrying the multiplicand and multiplier.
// Depends on rbm_pkg.
interface rbm_in_if;
    import rbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] mcand;
    logic [FIELD_W-1:0] mplier;

    modport source (output valid, output mcand, output mplier, input ready);
    modport sink   (input valid, input mcand, input mplier, output ready);
endinterface

>>> rtl/rbm_out_if.sv
// Result channel: valid/ready handshake carrying the product words and status.
// Depends on rbm_pkg.
interface rbm_out_if;
    import rbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] product_low;
    logic [FIELD_W-1:0] product_high;
    logic               done_flag;
    logic               signed_echo;
    logic [WCODE_W-1:0] width_echo;

    modport source (output valid, output product_low, output product_high,
                    output done_flag, output signed_echo, output width_echo, input ready);
    modport sink   (input valid, input product_low, input product_high,
                    input done_flag, input signed_echo, input width_echo, output ready);
endinterface

>>> rtl/rbm_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on rbm_pkg.
interface rbm_cfg_if;
    import rbm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rbm_prep.sv
// Stage 1: cuts both operands to the configured width and extends them by sign or zero.
// Depends on rbm_pkg.
module rbm_prep #(
    parameter int OPERAND_WIDTH = rbm_pkg::OPERAND_WIDTH_DEF,
    parameter int BX_W          = 2 * ((OPERAND_WIDTH + 2) / 2)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rbm_pkg::FIELD_W-1:0] mcand,
    input  logic [rbm_pkg::FIELD_W-1:0] mplier,
    input  rbm_pkg::rbm_meta_t          meta,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [OPERAND_WIDTH:0]      a_ext,
    output logic [BX_W-1:0]             b_ext,
    output rbm_pkg::rbm_meta_t          out_meta
);
    import rbm_pkg::*;

    localparam logic [5:0] OW_CAP = 6'(OPERAND_WIDTH);

    logic                   valid_reg;
    logic [OPERAND_WIDTH:0] a_reg, a_next;
    logic [BX_W-1:0]        b_reg, b_next;
    rbm_meta_t              meta_reg;
    logic [5:0]             w_full;
    logic [5:0]             w_eff;
    logic [4:0]             top_idx;
    logic                   sa, sb;
    logic                   load;

    assign w_full  = {1'b0, meta.width_code, 3'b000} + 6'd8;
    assign w_eff   = (w_full > OW_CAP) ? OW_CAP : w_full;
    assign top_idx = 5'(w_eff - 6'd1);
    assign sa      = meta.twos_comp & mcand[top_idx];
    assign sb      = meta.twos_comp & mplier[top_idx];

    always_comb
    begin
        a_next = '0;
        b_next = '0;
        for (int i = 0; i < OPERAND_WIDTH; i++)
        begin
            a_next[i] = (6'(i) < w_eff) ? mcand[i] : sa;
            b_next[i] = (6'(i) < w_eff) ? mplier[i] : sb;
        end
        a_next[OPERAND_WIDTH] = sa;
        for (int i = OPERAND_WIDTH; i < BX_W; i++)
        begin
            b_next[i] = sb;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            meta_reg <= meta;
        end
    end

    assign out_valid = valid_reg;
    assign a_ext     = a_reg;
    assign b_ext     = b_reg;
    assign out_meta  = meta_reg;

endmodule

>>> rtl/rbm_ppgen.sv
// Stage 2: radix-4 Booth recoding of the multiplier and one shifted partial product per group.
// Depends on rbm_pkg.
module rbm_ppgen #(
    parameter int OPERAND_WIDTH = rbm_pkg::OPERAND_WIDTH_DEF,
    parameter int BX_W          = 2 * ((OPERAND_WIDTH + 2) / 2),
    parameter int NG            = BX_W / 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OPERAND_WIDTH:0]     a_ext,
    input  logic [BX_W-1:0]            b_ext,
    input  rbm_pkg::rbm_meta_t         meta,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rbm_pkg::PROD_W-1:0] pp [NG],
    output rbm_pkg::rbm_meta_t         out_meta
);
    import rbm_pkg::*;

    logic              valid_reg;
    logic [PROD_W-1:0] pp_reg  [NG];
    logic [PROD_W-1:0] pp_next [NG];
    rbm_meta_t         meta_reg;
    logic [PROD_W-1:0] m1, m2;
    logic [BX_W:0]     b_pad;
    logic              load;

    assign m1    = {{(PROD_W-OPERAND_WIDTH-1){a_ext[OPERAND_WIDTH]}}, a_ext};
    assign m2    = {m1[PROD_W-2:0], 1'b0};
    // Implicit zero below bit 0 for the first group
    assign b_pad = {b_ext, 1'b0};

    for (genvar g = 0; g < NG; g++)
    begin : g_group
        booth_t            dig;
        logic [PROD_W-1:0] sel;

        assign dig = booth_decode(b_pad[2*g+2 -: 3]);

        always_comb
        begin
            case (dig)
                BOOTH_POS1: sel = m1;
                BOOTH_POS2: sel = m2;
                BOOTH_NEG2: sel = -m2;
                BOOTH_NEG1: sel = -m1;
                default:    sel = '0;
            endcase
        end

        assign pp_next[g] = sel << (2 * g);
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_reg   <= pp_next;
            meta_reg <= meta;
        end
    end

    assign out_valid = valid_reg;
    assign pp        = pp_reg;
    assign out_meta  = meta_reg;

endmodule

>>> rtl/rbm_add_stage.sv
// Adder tree stage: sums each run of FAN partial products into one registered word.
// Depends on rbm_pkg.
module rbm_add_stage #(
    parameter int N_IN  = 17,
    parameter int FAN   = 4,
    parameter int N_OUT = (N_IN + FAN - 1) / FAN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rbm_pkg::PROD_W-1:0] din [N_IN],
    input  rbm_pkg::rbm_meta_t         meta,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rbm_pkg::PROD_W-1:0] dout [N_OUT],
    output rbm_pkg::rbm_meta_t         out_meta
);
    import rbm_pkg::*;

    logic              valid_reg;
    logic [PROD_W-1:0] sum_reg  [N_OUT];
    logic [PROD_W-1:0] sum_next [N_OUT];
    rbm_meta_t         meta_reg;
    logic              load;

    always_comb
    begin
        for (int j = 0; j < N_OUT; j++)
        begin
            sum_next[j] = '0;
            for (int k = 0; k < FAN; k++)
            begin
                if (j * FAN + k < N_IN)
                begin
                    sum_next[j] = sum_next[j] + din[j*FAN+k];
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum_next;
            meta_reg <= meta;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = sum_reg;
    assign out_meta  = meta_reg;

endmodule

>>> rtl/radix4_booth_multiplier_unit.sv
// Top level of the radix-4 Booth multiplier: configuration registers and the four-stage pipeline.
// Depends on rbm_pkg, rbm_in_if, rbm_out_if, rbm_cfg_if, rbm_prep, rbm_ppgen, rbm_add_stage.
//
// Usage:
//   operands : one beat per multiply, carrying mcand (multiplicand) and mplier (multiplier).
//   result   : one beat per operand beat, in order: the 64-bit product as product_low and
//              product_high, done_flag (always one), and the mode and width code used.
//   cfg      : register writes, always ready. Index 0 is width_code (8/16/24/32 bits,
//              capped at OPERAND_WIDTH), index 1 is twos_comp. Write only while idle.
// Four register stages: operand extension, Booth recoding into one partial product per
// bit pair, a 4-input adder stage, and a final adder stage whose register drives the
// result channel. An operand beat passes through these four registers in that order
// before its result shows valid.
// Throughput is one beat per cycle while the receiver is ready; each stage register holds one item.
// When the receiver stalls, the final register holds its beat and each stage keeps
// loading while the stage after it has room, so up to four items wait inside before
// operands.ready drops. Nothing is lost or repeated.
// Reset clears all stage valid bits and sets width_code to 8 bits, unsigned mode.
module radix4_booth_multiplier_unit #(
    parameter int OPERAND_WIDTH = rbm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rbm_in_if.sink         operands,
    rbm_out_if.source      result,
    rbm_cfg_if.sink        cfg
);
    import rbm_pkg::*;

    localparam int BX_W  = 2 * ((OPERAND_WIDTH + 2) / 2);
    localparam int NG    = BX_W / 2;
    localparam int FAN1  = 4;
    localparam int NS    = (NG + FAN1 - 1) / FAN1;

    logic [WCODE_W-1:0] width_code_reg;
    logic               twos_comp_reg;
    rbm_meta_t          cfg_meta;

    logic                   p_valid, p_ready;
    logic [OPERAND_WIDTH:0] p_a;
    logic [BX_W-1:0]        p_b;
    rbm_meta_t              p_meta;

    logic              g_valid, g_ready;
    logic [PROD_W-1:0] g_pp [NG];
    rbm_meta_t         g_meta;

    logic              s_valid, s_ready;
    logic [PROD_W-1:0] s_sum [NS];
    rbm_meta_t         s_meta;

    logic [PROD_W-1:0] f_sum [1];
    rbm_meta_t         f_meta;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg <= '0;
            twos_comp_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIDTH_CODE: width_code_reg <= cfg.data[WCODE_W-1:0];
                REG_TWOS_COMP:  twos_comp_reg  <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    assign cfg_meta.twos_comp  = twos_comp_reg;
    assign cfg_meta.width_code = width_code_reg;

    rbm_prep #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .BX_W          (BX_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .mcand     (operands.mcand),
        .mplier    (operands.mplier),
        .meta      (cfg_meta),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .a_ext     (p_a),
        .b_ext     (p_b),
        .out_meta  (p_meta)
    );

    rbm_ppgen #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .BX_W          (BX_W),
        .NG            (NG)
    ) u_ppgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .a_ext     (p_a),
        .b_ext     (p_b),
        .meta      (p_meta),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .pp        (g_pp),
        .out_meta  (g_meta)
    );

    rbm_add_stage #(
        .N_IN  (NG),
        .FAN   (FAN1),
        .N_OUT (NS)
    ) u_add_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .din       (g_pp),
        .meta      (g_meta),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .dout      (s_sum),
        .out_meta  (s_meta)
    );

    // Final stage register doubles as the output register
    rbm_add_stage #(
        .N_IN  (NS),
        .FAN   (NS),
        .N_OUT (1)
    ) u_add_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .din       (s_sum),
        .meta      (s_meta),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .dout      (f_sum),
        .out_meta  (f_meta)
    );

    assign result.product_low  = f_sum[0][FIELD_W-1:0];
    assign result.product_high = f_sum[0][PROD_W-1:FIELD_W];
    assign result.done_flag    = 1'b1;
    assign result.signed_echo  = f_meta.twos_comp;
    assign result.width_echo   = f_meta.width_code;

endmodule

>>> bench/rbm_product_checker.sv
// Scoreboard for the radix-4 Booth multiplier: tracks register writes, predicts each product
// from the operand beats and compares it with the result beats in order.
// Depends on rbm_pkg and the rbm_in_if, rbm_out_if and rbm_cfg_if interfaces.
module rbm_product_checker #(
    parameter int OPERAND_WIDTH = rbm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rbm_in_if    ops,
    rbm_out_if   res,
    rbm_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding,
    output int   compared
);
    timeunit 1ns;
    timeprecision 1ps;

    import rbm_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] prod_low;
        logic [FIELD_W-1:0] prod_high;
        logic               done;
        logic               sgn;
        logic [WCODE_W-1:0] wcode;
    } product_t;

    product_t           products_due[$];
    logic [WCODE_W-1:0] width_code     = '0;
    logic               twos_comp      = 1'b0;
    int                 mismatch_count = 0;
    int                 due_count      = 0;
    int                 compared_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = due_count;
    assign compared    = compared_count;

    // Cut to the selected width, extend, and take the exact product modulo 2^64
    function automatic product_t predict_product(input logic [FIELD_W-1:0] a,
                                                 input logic [FIELD_W-1:0] b,
                                                 input logic [WCODE_W-1:0] wc,
                                                 input logic sgn);
        product_t         p;
        int               nbits;
        logic [PROD_W-1:0] mask, ea, eb, full;
        nbits = 8 * (int'(wc) + 1);
        if (nbits > OPERAND_WIDTH)
            nbits = OPERAND_WIDTH;
        mask = (64'd1 << nbits) - 64'd1;
        ea = {32'd0, a} & mask;
        eb = {32'd0, b} & mask;
        if (sgn && ea[nbits-1])
            ea = ea | ~mask;
        if (sgn && eb[nbits-1])
            eb = eb | ~mask;
        full        = ea * eb;
        p.prod_low  = full[31:0];
        p.prod_high = full[63:32];
        p.done      = 1'b1;
        p.sgn       = sgn;
        p.wcode     = wc;
        return p;
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("[%0t] beat %0d: %s expected %0h, got %0h", $time, compared_count, what,
                 want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_t got, want;
        if (!rst_n)
        begin
            width_code = '0;
            twos_comp  = 1'b0;
            products_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_WIDTH_CODE)
                    width_code = cfg.data[WCODE_W-1:0];
                else if (cfg.index == REG_TWOS_COMP)
                    twos_comp = cfg.data[0];
            end
            // Retire before predicting: a beat accepted now cannot be the one leaving now
            if (res.valid && res.ready)
            begin
                got = {res.product_low, res.product_high, res.done_flag, res.signed_echo,
                       res.width_echo};
                if (products_due.size() == 0)
                    report("result beat with nothing outstanding, low word", 0,
                           res.product_low);
                else
                begin
                    want = products_due.pop_front();
                    if (got.prod_low !== want.prod_low)
                        report("product_low", want.prod_low, got.prod_low);
                    if (got.prod_high !== want.prod_high)
                        report("product_high", want.prod_high, got.prod_high);
                    if (got.done !== want.done)
                        report("done_flag", want.done, got.done);
                    if (got.sgn !== want.sgn)
                        report("signed_echo", want.sgn, got.sgn);
                    if (got.wcode !== want.wcode)
                        report("width_echo", want.wcode, got.wcode);
                    compared_count++;
                end
            end
            if (ops.valid && ops.ready)
                products_due.push_back(predict_product(ops.mcand, ops.mplier,
                                                       width_code, twos_comp));
            due_count <= products_due.size();
        end
    end

endmodule

>>> bench/radix4_booth_multiplier_unit_test.sv
// Top of the multiplier bench: clock, reset, operand and register stimulus, receiver stalls
// and the verdict. Depends on rbm_pkg, the three channel interfaces, the block and
// rbm_product_checker.
module radix4_booth_multiplier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbm_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 62;
    localparam int DRAIN_CYCLES     = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int items_sent      = 0;
    int cycle_count     = 0;
    int mismatches, outstanding, compared;

    rbm_in_if  ops_if ();
    rbm_out_if res_if ();
    rbm_cfg_if cfg_if ();

    radix4_booth_multiplier_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (ops_if),
        .result   (res_if),
        .cfg      (cfg_if)
    );

    rbm_product_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ops         (ops_if),
        .res         (res_if),
        .cfg         (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d products outstanding",
                     cycle_count, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        res_if.ready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

    // Random operand, often with an extreme value inside the selected width
    function automatic logic [FIELD_W-1:0] pick_operand(input logic [WCODE_W-1:0] wc);
        int                 nbits;
        logic [FIELD_W-1:0] field_mask, raw;
        nbits      = 8 * (int'(wc) + 1);
        field_mask = (nbits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        raw        = $urandom;
        case ($urandom_range(0, 7))
            0: raw = raw & ~field_mask;
            1: raw = raw | field_mask;
            2: raw = (raw & ~field_mask) | (32'd1 << (nbits - 1));
            3: raw = (raw & ~field_mask) | (field_mask >> 1);
            4: raw = (raw & ~field_mask) | $urandom_range(0, 3);
            default: ;
        endcase
        return raw;
    endfunction

    // Called and returns at a falling edge; idle cycles come in the set share of cycles
    task automatic push_operands(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            ops_if.valid = 1'b0;
            @(negedge clk);
        end
        ops_if.valid  = 1'b1;
        ops_if.mcand  = a;
        ops_if.mplier = b;
        do
            @(posedge clk);
        while (!ops_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        ops_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
    endtask

    // Drain, then write both registers; upper data bits are junk and must be ignored
    task automatic apply_setting(input logic [WCODE_W-1:0] wc, input logic sgn);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_WIDTH_CODE, ($urandom & ~32'h3) | wc);
        write_reg(REG_TWOS_COMP, ($urandom & ~32'h1) | sgn);
        cfg_if.valid = 1'b0;
    endtask

    initial
    begin
        int mode;
        ops_if.valid  = 1'b0;
        ops_if.mcand  = '0;
        ops_if.mplier = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset setting: 8-bit unsigned, upper bits must be dropped
        push_operands(32'h0000_0000, 32'h0000_0000);
        push_operands(32'h0000_00FF, 32'h0000_00FF);
        push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_operands(32'h0000_0080, 32'h0000_0080);
        push_operands(32'h1234_567F, 32'hABCD_EF80);

        apply_setting(2'd3, 1'b1);
        push_operands(32'h8000_0000, 32'h8000_0000);
        push_operands(32'h7FFF_FFFF, 32'h8000_0000);
        push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_operands(32'hFFFF_FFFF, 32'h0000_0001);
        push_operands(32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // Unsigned multiplier with its top bit set needs the extra Booth group
        apply_setting(2'd3, 1'b0);
        push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_operands(32'h0000_0001, 32'h8000_0000);
        push_operands(32'hAAAA_AAAA, 32'h5555_5555);
        push_operands(32'h5555_5555, 32'hAAAA_AAAA);

        apply_setting(2'd1, 1'b1);
        push_operands(32'h0000_8000, 32'h0000_FFFF);
        push_operands(32'h1234_7FFF, 32'hABCD_8000);

        apply_setting(2'd2, 1'b0);
        push_operands(32'hFFFF_FFFF, 32'h0080_0000);
        push_operands(32'hFF00_0000, 32'h00FF_FFFF);

        apply_setting(2'd2, 1'b1);
        push_operands(32'h0080_0000, 32'h007F_FFFF);
        push_operands(32'h0080_0000, 32'h0080_0000);

        // Random phases: every width/mode pair, and each idling pattern
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            logic [WCODE_W-1:0] wc;
            logic               sgn;
            wc   = WCODE_W'(p % 4);
            sgn  = 1'(((p / 4) % 2) ^ (p % 2));
            mode = (p / 3) % 4;
            sender_idle_pct = 0;
            sink_stall_pct  = 0;
            apply_setting(wc, sgn);
            case (mode)
                1: sender_idle_pct = 60;
                2: sink_stall_pct  = 60;
                3:
                begin
                    sender_idle_pct = 22;
                    sink_stall_pct  = 22;
                end
                default: ;
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Hold the sender until the pipeline has emptied
                if (p % 3 == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_for_drain();
                push_operands(pick_operand(wc), pick_operand(wc));
            end
        end

        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d operand beats over all widths in both modes; %0d products checked",
                 items_sent, compared);
        $display("Idling covered none, sender 60%%, receiver 60%% and both at 22%%");
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
